@@ hw/rtl/ali_pkg.sv @@
// Shared types and constants for the packed list block.
package ali_pkg;

  // Sizes of the list.
  localparam int CAPACITY = 16;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  // Fixed field widths.
  localparam int OP_W    = 2;
  localparam int POS_W   = 8;
  localparam int CMP_W   = POS_W + 1;
  localparam int DATA_W  = 32;
  localparam int STAT_W  = 3;
  localparam int COUNT_W = 5;
  localparam int FPOS_W  = 4;

  // Operation codes.
  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_READ   = 2'd2
  } ali_op_t;

  // Result status codes.
  typedef enum logic [STAT_W-1:0] {
    ST_OK              = 3'd0,
    ST_BEYOND_CAPACITY = 3'd1,
    ST_FULL            = 3'd2,
    ST_NOT_FOUND       = 3'd3,
    ST_PAST_COUNT      = 3'd4
  } ali_status_t;

  // Command beat.
  typedef struct packed {
    logic [OP_W-1:0]          operation;
    logic [POS_W-1:0]         position;
    logic signed [DATA_W-1:0] value;
  } ali_in_t;

  // Result beat.
  typedef struct packed {
    logic [STAT_W-1:0]        status;
    logic [COUNT_W-1:0]       entry_count;
    logic [FPOS_W-1:0]        found_position;
    logic signed [DATA_W-1:0] read_value;
  } ali_out_t;

  // Per-cell update controls.
  typedef struct packed {
    logic load;
    logic take_left;
    logic take_right;
  } ali_ctl_t;

endpackage

@@ hw/rtl/array_list_insert_remove_top.sv @@
// Top level of the packed list: command capture, cell chain and result logic.
// Sequence: a command is captured when accepted and is executed in the busy cycle that it raises; its result
// beat is on the result port with done high in the cycle after that.
// A new command is not accepted while busy is high, which it is for the execute cycle;
// the cells compare the key in the accept cycle and shift in the execute cycle.
// Reset clears the fill count and the control flags; entry contents are left as they are.
// The result beat is shown for one cycle and the receiver cannot stall it.
module array_list_insert_remove_top (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  ali_pkg::ali_in_t  cmd,
  output logic              done,
  output ali_pkg::ali_out_t result
);
  import ali_pkg::*;

  logic                     accept;
  ali_in_t                  cmd_q;
  logic [CNT_W-1:0]         fill_count;
  logic [CNT_W-1:0]         fill_count_next;
  ali_out_t                 result_next;
  logic signed [DATA_W-1:0] cell_data [CAPACITY];
  logic [CAPACITY-1:0]      cell_match;
  ali_ctl_t                 cell_ctl [CAPACITY];
  logic [CAPACITY-1:0]      valid_mask;
  logic [CAPACITY-1:0]      hit_vec;
  logic [CAPACITY-1:0]      hit_low;
  logic [CAPACITY-1:0]      hit_ge;
  logic                     hit_any;
  logic [IDX_W-1:0]         hit_idx;
  logic                     pos_beyond;
  logic                     list_full;
  logic                     ins_past;
  logic                     read_past;
  logic                     ins_ok;
  logic                     rem_ok;
  logic [CMP_W-1:0]         pos_ext;

  assign accept = start && !busy;

  // Control and command capture.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy       <= 1'b0;
      done       <= 1'b0;
      fill_count <= '0;
    end else begin
      busy <= accept;
      done <= busy;
      if (busy) begin
        fill_count <= fill_count_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q <= cmd;
    end
    if (busy) begin
      result <= result_next;
    end
  end

  // Range checks on the captured position.
  assign pos_ext    = {1'b0, cmd_q.position};
  assign pos_beyond = (pos_ext >= CMP_W'(CAPACITY));
  assign list_full  = (fill_count == CNT_W'(CAPACITY));
  assign ins_past   = (pos_ext > CMP_W'(fill_count));
  assign read_past  = (pos_ext >= CMP_W'(fill_count));

  // Lowest matching held entry.
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      valid_mask[i] = (CNT_W'(i) < fill_count);
    end
  end

  assign hit_vec = cell_match & valid_mask;
  assign hit_any = |hit_vec;
  assign hit_low = hit_vec & (~hit_vec + CAPACITY'(1));
  assign hit_ge  = ~(hit_low - CAPACITY'(1));

  always_comb begin
    hit_idx = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (hit_low[i]) begin
        hit_idx = hit_idx | IDX_W'(i);
      end
    end
  end

  assign ins_ok = busy && (cmd_q.operation == OP_INSERT) && !pos_beyond && !list_full &&
                  !ins_past;
  assign rem_ok = busy && (cmd_q.operation == OP_REMOVE) && hit_any;

  // Per-cell shift controls.
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      cell_ctl[i].load       = ins_ok && (CMP_W'(i) == pos_ext);
      cell_ctl[i].take_left  = ins_ok && (CMP_W'(i) > pos_ext);
      cell_ctl[i].take_right = rem_ok && hit_ge[i];
    end
  end

  // Result and next fill count.
  always_comb begin
    fill_count_next            = fill_count;
    result_next.status         = ST_OK;
    result_next.found_position = '0;
    result_next.read_value     = '0;
    case (cmd_q.operation)
      OP_INSERT: begin
        if (pos_beyond) begin
          result_next.status = ST_BEYOND_CAPACITY;
        end else if (list_full) begin
          result_next.status = ST_FULL;
        end else if (ins_past) begin
          result_next.status = ST_PAST_COUNT;
        end else begin
          fill_count_next = fill_count + CNT_W'(1);
        end
      end
      OP_REMOVE: begin
        if (!hit_any) begin
          result_next.status = ST_NOT_FOUND;
        end else begin
          fill_count_next            = fill_count - CNT_W'(1);
          result_next.found_position = FPOS_W'(hit_idx);
        end
      end
      OP_READ: begin
        if (pos_beyond) begin
          result_next.status = ST_BEYOND_CAPACITY;
        end else if (read_past) begin
          result_next.status = ST_PAST_COUNT;
        end else begin
          result_next.read_value = cell_data[cmd_q.position[IDX_W-1:0]];
        end
      end
      default: begin
      end
    endcase
    result_next.entry_count = COUNT_W'(fill_count_next);
  end

  // Chain of cells; each takes from its left or right neighbor.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [DATA_W-1:0] left_in;
    logic signed [DATA_W-1:0] right_in;

    if (i == 0) begin : g_first
      assign left_in = '0;
    end else begin : g_inner_l
      assign left_in = cell_data[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_in = '0;
    end else begin : g_inner_r
      assign right_in = cell_data[i+1];
    end

    ali_cell u_cell (
      .clk        (clk),
      .cmp_en     (accept),
      .key        (cmd.value),
      .ctl        (cell_ctl[i]),
      .ins_data   (cmd_q.value),
      .left_data  (left_in),
      .right_data (right_in),
      .data       (cell_data[i]),
      .match      (cell_match[i])
    );
  end

  // Checks on sequencing and count bounds.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> busy)
    else $error("busy not raised after an accepted command");

  a_busy_done: assert property (@(posedge clk) disable iff (rst)
    busy |=> done && !busy)
    else $error("execute cycle not followed by a single result beat");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    fill_count <= CNT_W'(CAPACITY))
    else $error("fill count exceeds capacity");

  a_full_count: assert property (@(posedge clk) disable iff (rst)
    done && (result.status == ST_FULL) |-> result.entry_count == COUNT_W'(CAPACITY))
    else $error("full status reported with list not full");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    done |-> (fill_count == $past(fill_count)) ||
             (fill_count == $past(fill_count) + CNT_W'(1)) ||
             (fill_count == $past(fill_count) - CNT_W'(1)))
    else $error("fill count moved by more than one entry");

endmodule

@@ hw/rtl/ali_cell.sv @@
// One storage cell of the list: holds an entry, compares it, and shifts.
module ali_cell (
  input  logic                              clk,
  input  logic                              cmp_en,
  input  logic signed [ali_pkg::DATA_W-1:0] key,
  input  ali_pkg::ali_ctl_t                 ctl,
  input  logic signed [ali_pkg::DATA_W-1:0] ins_data,
  input  logic signed [ali_pkg::DATA_W-1:0] left_data,
  input  logic signed [ali_pkg::DATA_W-1:0] right_data,
  output logic signed [ali_pkg::DATA_W-1:0] data,
  output logic                              match
);
  import ali_pkg::*;

  // Entry update: load a new value or take a neighbor's entry.
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      data <= ins_data;
    end else if (ctl.take_left) begin
      data <= left_data;
    end else if (ctl.take_right) begin
      data <= right_data;
    end
  end

  // Compare result is captured when a command is accepted.
  always_ff @(posedge clk) begin
    if (cmp_en) begin
      match <= (data == key);
    end
  end

endmodule
